### sv/segment_tree_range_combine_assert.svh
// assertion macros for the segment tree range combine block
// expects clk and rst_n in the scope of every use
`ifndef SEGMENT_TREE_RANGE_COMBINE_ASSERT_SVH
`define SEGMENT_TREE_RANGE_COMBINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment tree assertion failed");

// next-cycle implication
`define STRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment tree assertion failed");

`else

`define STRC_ASSERT_SAME(label, ante, cons)
`define STRC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/strc_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the segment tree range combine block
// no dependencies
package strc_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic {
    CMB_SUM = 1'b0,
    CMB_MIN = 1'b1
  } cmb_mode_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_IDX_MODE   = 2'd0;
  localparam cfg_idx_t CFG_IDX_LENGTH = 2'd1;

  localparam len_t  LEN_RESET    = 11'd1024;
  localparam data_t SUM_IDENTITY = 32'sh0000_0000;
  localparam data_t MIN_IDENTITY = 32'sh7FFF_FFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUILD_RD,
    ST_BUILD_WR,
    ST_UP_RD,
    ST_UP_WR,
    ST_Q_LO,
    ST_Q_HI,
    ST_DONE
  } state_t;

  function automatic data_t cmb_identity(cmb_mode_t mode);
    return (mode == CMB_MIN) ? MIN_IDENTITY : SUM_IDENTITY;
  endfunction

endpackage

### sv/strc_in_if.sv
`timescale 1ns / 1ps
// input channel of the segment tree block: write or query beats
// depends on strc_pkg
interface strc_in_if;
  logic                valid;
  logic                ready;
  strc_pkg::kind_t     kind;
  strc_pkg::idx_t      first_index;
  strc_pkg::idx_t      last_index;
  strc_pkg::data_t     element_value;

  modport source (output valid, kind, first_index, last_index, element_value, input ready);
  modport sink   (input valid, kind, first_index, last_index, element_value, output ready);
endinterface

### sv/strc_out_if.sv
`timescale 1ns / 1ps
// result channel of the segment tree block
// depends on strc_pkg
interface strc_out_if;
  logic            valid;
  logic            ready;
  strc_pkg::data_t range_result;
  logic            range_error;

  modport source (output valid, range_result, range_error, input ready);
  modport sink   (input valid, range_result, range_error, output ready);
endinterface

### sv/strc_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel of the segment tree block
// depends on strc_pkg
interface strc_cfg_if;
  logic                valid;
  logic                ready;
  strc_pkg::cfg_idx_t  index;
  strc_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/segment_tree_range_combine.sv
`timescale 1ns / 1ps
// top level of the segment tree range combine block: node memory, sequencer
// depends on strc_pkg, strc_in_if, strc_out_if, strc_cfg_if, strc_combine and the assert header
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind, first_index, last_index, element_value
//   out_ch   out  valid/ready    range_result, range_error
//   cfg_ch   in   valid/ready    index, data (ready is always high)
//
// one item at a time; the node memory (one write port, two read ports) sets the pace
// write: the leaf first, then for each tree level a read of the children and a write of the parent
// query: a Q_LO and a Q_HI step for each visited level, then DONE
// range error: straight from IDLE to DONE; a result waits in DONE while the output register is still full
// after reset a clearing pass zeroes the memory before any beat
// a write to a known register index triggers a rebuild of all inner nodes
`include "segment_tree_range_combine_assert.svh"

module segment_tree_range_combine #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  strc_in_if.sink     in_ch,
  strc_out_if.source  out_ch,
  strc_cfg_if.sink    cfg_ch
);

  // node address width, pointer width (lo/hi may reach 2*MAX_ELEMENTS), limit width
  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int LW    = ($clog2(MAX_ELEMENTS + 1) > strc_pkg::LEN_W) ?
                         $clog2(MAX_ELEMENTS + 1) : strc_pkg::LEN_W;

  typedef logic [AW-1:0] addr_t;
  typedef logic [NW-1:0] ptr_t;
  typedef logic [LW-1:0] lim_t;

  localparam addr_t ADDR_LAST = AW'(DEPTH - 1);
  localparam addr_t NODE_TOP  = AW'(MAX_ELEMENTS - 1);
  localparam addr_t ROOT      = AW'(1);
  localparam lim_t  LIMIT_MAX = LW'(MAX_ELEMENTS);
  localparam ptr_t  LEAF_BASE = NW'(MAX_ELEMENTS);

  // control and datapath registers
  strc_pkg::state_t    state_r, state_nxt;
  addr_t               p_r, p_nxt;
  ptr_t                lo_r, lo_nxt;
  ptr_t                hi_r, hi_nxt;
  strc_pkg::data_t     acc_r, acc_nxt;
  logic                err_r, err_nxt;
  logic                pend_r, pend_nxt;
  strc_pkg::cmb_mode_t mode_r, mode_nxt;
  strc_pkg::len_t      len_r, len_nxt;
  logic                out_valid_r, out_valid_nxt;
  strc_pkg::data_t     out_result_r, out_result_nxt;
  logic                out_error_r, out_error_nxt;

  // node memory
  strc_pkg::data_t     tree_mem_r [DEPTH];
  strc_pkg::data_t     rd_a_r, rd_b_r;
  logic                mem_we;
  addr_t               mem_wa, mem_ra, mem_rb;
  strc_pkg::data_t     mem_wd;

  // shared combine unit operands
  strc_pkg::data_t     op_a, op_b, cmb_y;

  // item decode
  logic                in_acc, cfg_wr, cfg_hit, out_free;
  lim_t                limit, len_ext, first_ext, last_ext;
  logic                item_err;
  ptr_t                leaf_lo, leaf_hi, leaf_hi_even;
  ptr_t                lo_up, nlo, nhi, nhi_even;

  // ---------------- handshakes ----------------
  assign in_ch.ready  = (state_r == strc_pkg::ST_IDLE) && !pend_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.range_result = out_result_r;
  assign out_ch.range_error  = out_error_r;

  // ---------------- configuration registers ----------------
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    cfg_hit  = 1'b0;
    if (cfg_wr) begin
      priority if (cfg_ch.index == strc_pkg::CFG_IDX_MODE) begin
        mode_nxt = strc_pkg::cmb_mode_t'(cfg_ch.data[0]);
        cfg_hit  = 1'b1;
      end else if (cfg_ch.index == strc_pkg::CFG_IDX_LENGTH) begin
        len_nxt  = cfg_ch.data[strc_pkg::LEN_W-1:0];
        cfg_hit  = 1'b1;
      end else begin
        // unknown register index: ignored
        cfg_hit  = 1'b0;
      end
    end
  end

  // ---------------- range check and leaf pointers ----------------
  // used length clamps to MAX_ELEMENTS
  assign len_ext   = LW'(len_r);
  assign limit     = (len_ext > LIMIT_MAX) ? LIMIT_MAX : len_ext;
  assign first_ext = LW'(in_ch.first_index);
  assign last_ext  = LW'(in_ch.last_index);
  assign item_err  = (first_ext >= limit) ||
                     ((in_ch.kind == strc_pkg::KIND_QUERY) &&
                      ((last_ext >= limit) || (first_ext > last_ext)));

  // leaf pointers only matter for in-range indexes, so truncation is harmless
  assign leaf_lo      = LEAF_BASE + NW'(in_ch.first_index);
  assign leaf_hi      = LEAF_BASE + NW'(in_ch.last_index) + NW'(1);
  assign leaf_hi_even = {leaf_hi[NW-1:1], 1'b0};

  // next query level: lo rounds up, hi rounds down
  assign lo_up    = lo_r + NW'(lo_r[0]);
  assign nlo      = lo_up >> 1;
  assign nhi      = hi_r >> 1;
  assign nhi_even = {nhi[NW-1:1], 1'b0};

  // ---------------- shared combine unit ----------------
  assign op_a = ((state_r == strc_pkg::ST_Q_LO) || (state_r == strc_pkg::ST_Q_HI)) ?
                acc_r : rd_a_r;
  assign op_b = (state_r == strc_pkg::ST_Q_LO) ? rd_a_r : rd_b_r;

  strc_combine u_combine (
    .mode (mode_r),
    .a    (op_a),
    .b    (op_b),
    .y    (cmb_y)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    mem_we         = 1'b0;
    mem_wa         = p_r;
    mem_wd         = cmb_y;
    // children of p by default
    mem_ra         = {p_r[AW-2:0], 1'b0};
    mem_rb         = {p_r[AW-2:0], 1'b1};

    unique case (state_r)
      strc_pkg::ST_CLEAR: begin
        // zero one node per cycle
        mem_we = 1'b1;
        mem_wd = strc_pkg::SUM_IDENTITY;
        if (p_r == ADDR_LAST) begin
          state_nxt = strc_pkg::ST_IDLE;
        end else begin
          p_nxt = p_r + AW'(1);
        end
      end

      strc_pkg::ST_IDLE: begin
        // fetch the first query level speculatively
        mem_ra = leaf_lo[AW-1:0];
        mem_rb = leaf_hi_even[AW-1:0];
        if (pend_r) begin
          pend_nxt  = 1'b0;
          p_nxt     = NODE_TOP;
          state_nxt = strc_pkg::ST_BUILD_RD;
        end else if (in_acc) begin
          acc_nxt = strc_pkg::cmb_identity(mode_r);
          err_nxt = item_err;
          if (item_err) begin
            acc_nxt   = strc_pkg::SUM_IDENTITY;
            state_nxt = strc_pkg::ST_DONE;
          end else if (in_ch.kind == strc_pkg::KIND_WRITE) begin
            mem_we    = 1'b1;
            mem_wa    = leaf_lo[AW-1:0];
            mem_wd    = in_ch.element_value;
            p_nxt     = leaf_lo[AW-1:0] >> 1;
            state_nxt = strc_pkg::ST_UP_RD;
          end else begin
            lo_nxt    = leaf_lo;
            hi_nxt    = leaf_hi;
            state_nxt = strc_pkg::ST_Q_LO;
          end
        end
      end

      strc_pkg::ST_BUILD_RD: begin
        state_nxt = strc_pkg::ST_BUILD_WR;
      end

      strc_pkg::ST_BUILD_WR: begin
        mem_we = 1'b1;
        if (p_r == ROOT) begin
          state_nxt = strc_pkg::ST_IDLE;
        end else begin
          p_nxt     = p_r - AW'(1);
          state_nxt = strc_pkg::ST_BUILD_RD;
        end
      end

      strc_pkg::ST_UP_RD: begin
        state_nxt = strc_pkg::ST_UP_WR;
      end

      strc_pkg::ST_UP_WR: begin
        mem_we = 1'b1;
        if (p_r == ROOT) begin
          state_nxt = strc_pkg::ST_IDLE;
        end else begin
          p_nxt     = p_r >> 1;
          state_nxt = strc_pkg::ST_UP_RD;
        end
      end

      strc_pkg::ST_Q_LO: begin
        // keep both border nodes of this level on the read ports
        mem_ra = lo_r[AW-1:0];
        mem_rb = {hi_r[AW-1:1], 1'b0};
        // left border node joins when lo is a right child
        if (lo_r[0]) begin
          acc_nxt = cmb_y;
        end
        state_nxt = strc_pkg::ST_Q_HI;
      end

      strc_pkg::ST_Q_HI: begin
        // right border node joins when hi is a right child; fetch next level
        if (hi_r[0]) begin
          acc_nxt = cmb_y;
        end
        lo_nxt = nlo;
        hi_nxt = nhi;
        mem_ra = nlo[AW-1:0];
        mem_rb = nhi_even[AW-1:0];
        if (nlo < nhi) begin
          state_nxt = strc_pkg::ST_Q_LO;
        end else begin
          state_nxt = strc_pkg::ST_DONE;
        end
      end

      strc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          out_error_nxt  = err_r;
          state_nxt      = strc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = strc_pkg::ST_IDLE;
      end
    endcase

    // a register write asks for a rebuild under the new settings
    if (cfg_hit) begin
      pend_nxt = 1'b1;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= strc_pkg::ST_CLEAR;
      p_r         <= '0;
      pend_r      <= 1'b0;
      mode_r      <= strc_pkg::CMB_SUM;
      len_r       <= strc_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      pend_r      <= pend_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    acc_r        <= acc_nxt;
    err_r        <= err_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  // node memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem_r[mem_wa] <= mem_wd;
    end
    rd_a_r <= tree_mem_r[mem_ra];
    rd_b_r <= tree_mem_r[mem_rb];
  end

  // ---------------- assertions ----------------
  // node 0 is only written by the clearing pass
  `STRC_ASSERT_SAME(a_no_node0_write, mem_we && (state_r != strc_pkg::ST_CLEAR), mem_wa != '0)
  // the query walk only runs on a non-empty window
  `STRC_ASSERT_SAME(a_query_window, state_r == strc_pkg::ST_Q_LO, lo_r < hi_r)
  // an accepted beat always starts work
  `STRC_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != strc_pkg::ST_IDLE)
  // the update walk ends right after the root is written
  `STRC_ASSERT_NEXT(a_root_ends_update, (state_r == strc_pkg::ST_UP_WR) && (p_r == ROOT), state_r == strc_pkg::ST_IDLE)
  // error results carry a zero value
  `STRC_ASSERT_SAME(a_error_zero, out_valid_r && out_error_r, out_result_r == strc_pkg::SUM_IDENTITY)

endmodule

### sv/strc_combine.sv
`timescale 1ns / 1ps
// shared combine unit: wrapping 32-bit sum or signed minimum
// depends on strc_pkg
module strc_combine (
  input  strc_pkg::cmb_mode_t mode,
  input  strc_pkg::data_t     a,
  input  strc_pkg::data_t     b,
  output strc_pkg::data_t     y
);

  always_comb begin
    unique case (mode)
      strc_pkg::CMB_MIN: y = (a <= b) ? a : b;
      strc_pkg::CMB_SUM: y = a + b;
      default:           y = a + b;
    endcase
  end

endmodule

### test/segment_tree_range_combine_tb.sv
`timescale 1ns / 1ps
// self-checking bench for segment_tree_range_combine: element writes and range queries
// depends on strc_pkg, the three channel interfaces and the block itself
module segment_tree_range_combine_tb;

  localparam int TREE_LEAVES = 1024;
  // an in-range write finishes without a result, and a known register write starts a full
  // rebuild of the inner nodes, so a new register write waits this long first
  localparam int SETTLE_CYCLES = 2100;
  localparam int TAIL_CYCLES = 100;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 50;

  // register indexes that lie past the two real registers
  localparam strc_pkg::cfg_idx_t CFG_IDX_SPARE_LO = 2'd2;
  localparam strc_pkg::cfg_idx_t CFG_IDX_SPARE_HI = 2'd3;

  // one entry of the stimulus list: an input beat, a register write,
  // or a pause until every awaited result has come back
  typedef enum logic [1:0] {
    STEP_BEAT,
    STEP_SETUP,
    STEP_DRAIN
  } step_op_t;

  typedef struct packed {
    step_op_t            op;
    strc_pkg::kind_t     kind;
    strc_pkg::idx_t      first_index;
    strc_pkg::idx_t      last_index;
    strc_pkg::data_t     element_value;
    strc_pkg::cfg_idx_t  reg_index;
    strc_pkg::cfg_data_t reg_data;
  } step_t;

  typedef struct packed {
    strc_pkg::data_t range_result;
    logic            range_error;
  } answer_t;

  logic clk;
  logic rst_n;

  strc_in_if  in_bus();
  strc_out_if out_bus();
  strc_cfg_if cfg_bus();

  segment_tree_range_combine #(
    .MAX_ELEMENTS(TREE_LEAVES)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // shadow of the block: node array, mode and length as the block should hold them
  // ---------------------------------------------------------------------------
  logic [strc_pkg::DATA_W-1:0] node_store [0:2*TREE_LEAVES-1];
  strc_pkg::cmb_mode_t         shadow_mode;
  strc_pkg::len_t              shadow_length;

  step_t   work_list[$];      // stimulus waiting for the driver
  answer_t combined_due[$];   // results the block still owes, oldest first
  int      fault_count;

  function automatic logic [strc_pkg::DATA_W-1:0] merge(logic [strc_pkg::DATA_W-1:0] a,
                                                        logic [strc_pkg::DATA_W-1:0] b);
    if (shadow_mode == strc_pkg::CMB_MIN) begin
      return ($signed(a) <= $signed(b)) ? a : b;
    end
    return a + b;  // wraps at 32 bits
  endfunction

  // recompute every inner node from the leaves, bottom up
  function automatic void refold_tree();
    for (int p = TREE_LEAVES - 1; p >= 1; p--) begin
      node_store[p] = merge(node_store[2*p], node_store[2*p+1]);
    end
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < 2*TREE_LEAVES; i++) begin
      node_store[i] = '0;
    end
    shadow_mode   = strc_pkg::CMB_SUM;
    shadow_length = strc_pkg::LEN_RESET;
  endfunction

  // lengths above the tree size count as the full tree
  function automatic int unsigned reach();
    return (shadow_length > TREE_LEAVES) ? TREE_LEAVES : shadow_length;
  endfunction

  function automatic void apply_register(strc_pkg::cfg_idx_t index, strc_pkg::cfg_data_t data);
    if (index == strc_pkg::CFG_IDX_MODE) begin
      shadow_mode = strc_pkg::cmb_mode_t'(data[0]);
    end else if (index == strc_pkg::CFG_IDX_LENGTH) begin
      shadow_length = data;
    end else begin
      return;  // unknown register: no effect, no rebuild
    end
    refold_tree();
  endfunction

  // work out what an accepted beat does to the tree and what it should return
  function automatic void predict_beat(step_t s);
    int unsigned                 n;
    int unsigned                 p;
    int unsigned                 lo;
    int unsigned                 hi;
    logic [strc_pkg::DATA_W-1:0] acc;
    answer_t                     a;
    n = reach();
    a.range_result = '0;
    a.range_error  = 1'b1;
    if (s.kind == strc_pkg::KIND_WRITE) begin
      if (s.first_index >= n) begin
        combined_due.push_back(a);
        return;
      end
      p = TREE_LEAVES + s.first_index;
      node_store[p] = s.element_value;
      // walk the path to the root
      while (p > 1) begin
        p = p >> 1;
        node_store[p] = merge(node_store[2*p], node_store[2*p+1]);
      end
      return;
    end
    if (s.first_index >= n || s.last_index >= n || s.first_index > s.last_index) begin
      combined_due.push_back(a);
      return;
    end
    // bottom-up range walk: only nodes wholly inside the range take part
    lo  = TREE_LEAVES + s.first_index;
    hi  = TREE_LEAVES + s.last_index + 1;
    acc = (shadow_mode == strc_pkg::CMB_MIN) ? strc_pkg::MIN_IDENTITY : strc_pkg::SUM_IDENTITY;
    while (lo < hi) begin
      if (lo[0]) begin
        acc = merge(acc, node_store[lo]);
        lo++;
      end
      if (hi[0]) begin
        hi--;
        acc = merge(acc, node_store[hi]);
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    a.range_result = acc;
    a.range_error  = 1'b0;
    combined_due.push_back(a);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus list helpers
  // ---------------------------------------------------------------------------
  function automatic void add_beat(strc_pkg::kind_t k, strc_pkg::idx_t f, strc_pkg::idx_t l,
                                   strc_pkg::data_t v);
    step_t s;
    s = '0;
    s.op            = STEP_BEAT;
    s.kind          = k;
    s.first_index   = f;
    s.last_index    = l;
    s.element_value = v;
    work_list.push_back(s);
  endfunction

  function automatic void add_setup(strc_pkg::cfg_idx_t index, strc_pkg::cfg_data_t data);
    step_t s;
    s = '0;
    s.op        = STEP_SETUP;
    s.reg_index = index;
    s.reg_data  = data;
    work_list.push_back(s);
  endfunction

  function automatic void add_drain();
    step_t s;
    s = '0;
    s.op = STEP_DRAIN;
    work_list.push_back(s);
  endfunction

  // extremes are drawn often so that min and wrapping sum both see them
  function automatic strc_pkg::data_t pick_value();
    case ($urandom_range(0, 5))
      0:       return strc_pkg::MIN_IDENTITY;
      1:       return 32'sh8000_0000;
      2:       return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // one random beat for a given used length: mostly legal writes and queries,
  // some noise with raw 10-bit indexes that may or may not fall in range
  function automatic step_t make_beat(int unsigned len);
    step_t       s;
    int unsigned n;
    int unsigned r;
    int unsigned a;
    int unsigned b;
    s = '0;
    s.op = STEP_BEAT;
    n = (len > TREE_LEAVES) ? TREE_LEAVES : len;
    r = $urandom_range(0, 99);
    // unused fields carry junk so their bits toggle as well
    s.last_index    = strc_pkg::idx_t'($urandom_range(0, TREE_LEAVES - 1));
    s.element_value = $urandom;
    if (n > 0 && r < 40) begin
      s.kind          = strc_pkg::KIND_WRITE;
      s.first_index   = strc_pkg::idx_t'($urandom_range(0, n - 1));
      s.element_value = pick_value();
    end else if (n > 0 && r < 85) begin
      s.kind = strc_pkg::KIND_QUERY;
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if (a > b) begin
        s.first_index = strc_pkg::idx_t'(b);
        s.last_index  = strc_pkg::idx_t'(a);
      end else begin
        s.first_index = strc_pkg::idx_t'(a);
        s.last_index  = strc_pkg::idx_t'(b);
      end
      // narrow ranges now and then
      if ($urandom_range(0, 2) == 0) begin
        b = a + $urandom_range(0, 3);
        s.first_index = strc_pkg::idx_t'(a);
        s.last_index  = strc_pkg::idx_t'((b >= n) ? n - 1 : b);
      end
    end else begin
      s.kind        = strc_pkg::kind_t'($urandom_range(0, 1));
      s.first_index = strc_pkg::idx_t'($urandom_range(0, TREE_LEAVES - 1));
      s.last_index  = strc_pkg::idx_t'($urandom_range(0, TREE_LEAVES - 1));
    end
    return s;
  endfunction

  // per-beat wait, with runs of zero waits toggled at random
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) begin
      burst = ~burst;
    end
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic void note_fault(string what, answer_t want, strc_pkg::data_t got_v,
                                     logic got_e);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected result %h error %b, got result %h error %b",
               $time, what, want.range_result, want.range_error, got_v, got_e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // driver: takes entries off the list, presents beats and register writes
  // ---------------------------------------------------------------------------
  step_t current;
  logic  in_busy;
  logic  cfg_busy;
  logic  settling;
  int    gap_left;
  int    settle_left;
  bit    send_burst;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_busy     = 1'b0;
      cfg_busy    = 1'b0;
      settling    = 1'b0;
      gap_left    = 0;
      settle_left = 0;
      shadow_reset();
      in_bus.valid  <= 1'b0;
      cfg_bus.valid <= 1'b0;
    end else begin
      // beat taken: update the shadow tree and draw the gap before the next one
      if (in_bus.valid && in_bus.ready) begin
        predict_beat(current);
        in_busy  = 1'b0;
        gap_left = draw_wait(send_burst);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        apply_register(current.reg_index, current.reg_data);
        cfg_busy = 1'b0;
      end
      if (!in_busy && !cfg_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (work_list.size() > 0) begin
          case (work_list[0].op)
            STEP_BEAT: begin
              current = work_list.pop_front();
              in_busy = 1'b1;
              in_bus.kind          <= current.kind;
              in_bus.first_index   <= current.first_index;
              in_bus.last_index    <= current.last_index;
              in_bus.element_value <= current.element_value;
            end
            STEP_DRAIN: begin
              // hold back until every owed result is in
              if (combined_due.size() == 0) begin
                void'(work_list.pop_front());
              end
            end
            STEP_SETUP: begin
              // registers change only once the block has gone quiet
              if (settling) begin
                if (settle_left > 0) begin
                  settle_left--;
                end else begin
                  current  = work_list.pop_front();
                  cfg_busy = 1'b1;
                  settling = 1'b0;
                  cfg_bus.index <= current.reg_index;
                  cfg_bus.data  <= current.reg_data;
                end
              end else if (combined_due.size() == 0) begin
                settling    = 1'b1;
                settle_left = SETTLE_CYCLES;
              end
            end
            default: begin
              void'(work_list.pop_front());
            end
          endcase
        end
      end
      in_bus.valid  <= in_busy;
      cfg_bus.valid <= cfg_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stalls on the result side, compares each result beat
  // ---------------------------------------------------------------------------
  int      stall_left;
  bit      take_burst;
  answer_t due_head;

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        due_head = '0;
        if (combined_due.size() == 0) begin
          note_fault("result beat with nothing awaited", due_head,
                     out_bus.range_result, out_bus.range_error);
        end else begin
          due_head = combined_due.pop_front();
          if (out_bus.range_result !== due_head.range_result ||
              out_bus.range_error !== due_head.range_error) begin
            note_fault("result mismatch", due_head, out_bus.range_result, out_bus.range_error);
          end
        end
        stall_left = draw_wait(take_burst);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_bus.ready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_len [PHASES];
    step_t       s;

    fault_count = 0;
    send_burst  = 1'b0;
    take_burst  = 1'b0;
    // known values on every input from time zero
    in_bus.valid         = 1'b0;
    in_bus.kind          = strc_pkg::KIND_WRITE;
    in_bus.first_index   = '0;
    in_bus.last_index    = '0;
    in_bus.element_value = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = strc_pkg::CFG_IDX_MODE;
    cfg_bus.data         = '0;
    out_bus.ready        = 1'b0;

    // directed: sum mode, full length after reset
    add_beat(strc_pkg::KIND_WRITE, 10'd0, 10'd1023, strc_pkg::MIN_IDENTITY);
    add_beat(strc_pkg::KIND_WRITE, 10'd1023, 10'd0, 32'sh8000_0000);
    add_beat(strc_pkg::KIND_WRITE, 10'd1, 10'd0, -32'sd1);
    add_beat(strc_pkg::KIND_WRITE, 10'd512, 10'd0, 32'sd1);
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd1023, '0);   // whole tree, sum wraps
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd0, '0);
    add_beat(strc_pkg::KIND_QUERY, 10'd1023, 10'd1023, '0);
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd1, '0);
    add_beat(strc_pkg::KIND_QUERY, 10'd5, 10'd5, '0);      // untouched leaf reads zero
    add_beat(strc_pkg::KIND_QUERY, 10'd3, 10'd2, '0);      // reversed range
    add_beat(strc_pkg::KIND_QUERY, 10'd1023, 10'd0, '0);
    // length above the tree size counts as the full tree
    add_setup(strc_pkg::CFG_IDX_LENGTH, 11'd2047);
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd1023, '0);
    // minimum mode; upper data bits are don't-care
    add_setup(strc_pkg::CFG_IDX_MODE, 11'h7FF);
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd1023, '0);
    add_beat(strc_pkg::KIND_QUERY, 10'd2, 10'd511, '0);
    add_beat(strc_pkg::KIND_QUERY, 10'd1, 10'd1, '0);
    // single element
    add_setup(strc_pkg::CFG_IDX_LENGTH, 11'd1);
    add_beat(strc_pkg::KIND_WRITE, 10'd1, 10'd0, 32'sd5);  // write past the end
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd1, '0);
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd0, '0);
    add_beat(strc_pkg::KIND_WRITE, 10'd0, 10'd0, -32'sd7);
    // zero length: every index is out of range
    add_setup(strc_pkg::CFG_IDX_LENGTH, 11'd0);
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd0, '0);
    add_beat(strc_pkg::KIND_WRITE, 10'd0, 10'd0, 32'sd3);
    // writes to indexes past the register list do nothing
    add_setup(CFG_IDX_SPARE_LO, 11'h555);
    add_setup(CFG_IDX_SPARE_HI, 11'h2AA);
    // back to full length and sum; hidden leaves come back into view
    add_setup(strc_pkg::CFG_IDX_LENGTH, strc_pkg::LEN_RESET);
    add_setup(strc_pkg::CFG_IDX_MODE, 11'h002);
    add_beat(strc_pkg::KIND_QUERY, 10'd1023, 10'd1023, '0);
    add_beat(strc_pkg::KIND_QUERY, 10'd0, 10'd1023, '0);
    add_beat(strc_pkg::KIND_WRITE, 10'd1023, 10'd0, strc_pkg::MIN_IDENTITY);
    add_beat(strc_pkg::KIND_QUERY, 10'd512, 10'd1023, '0);

    // random phases, each under its own mode and length
    phase_len[0] = 1024;
    phase_len[1] = $urandom_range(2, 64);
    phase_len[2] = 1024;
    phase_len[3] = $urandom_range(1, 8);
    phase_len[4] = $urandom_range(100, 1023);
    phase_len[5] = 1500;
    phase_len[6] = $urandom_range(2, 64);
    phase_len[7] = 1024;
    for (int ph = 0; ph < PHASES; ph++) begin
      add_setup(strc_pkg::CFG_IDX_MODE, strc_pkg::cfg_data_t'($urandom_range(0, 2047)));
      add_setup(strc_pkg::CFG_IDX_LENGTH, strc_pkg::cfg_data_t'(phase_len[ph]));
      for (int k = 0; k < PHASE_BEATS; k++) begin
        // in even phases the sender holds off mid-phase until the block has caught up
        if (k == PHASE_BEATS / 2 && ph[0] == 1'b0) begin
          add_drain();
        end
        s = make_beat(phase_len[ph]);
        work_list.push_back(s);
      end
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (work_list.size() > 0 || in_busy || cfg_busy || combined_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (combined_due.size() != 0) begin
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard limit: far beyond the slowest legal run, clearing pass and rebuilds included
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
